[sv/wmf_pkg.sv]
// shared types and constants for the window minimum filter
`default_nettype none
package wmf_pkg;
	localparam int DataWidth = 32;
	localparam int MaxSide   = 1024;
	localparam int MaxWin    = 32;
	localparam int SideW     = 11;
	localparam int WinW      = 6;
	localparam int PosW      = 10;
	localparam int RowSelW   = 5;
	localparam int CntW      = 6;
	localparam int QueueDepth = 4;
	localparam int QPtrW     = 2;
	localparam int QCntW     = 3;

	localparam logic [1:0] RegImageSide  = 2'd0;
	localparam logic [1:0] RegWindowSize = 2'd1;

	typedef struct packed {
		logic signed [DataWidth-1:0] hmin;
		logic [RowSelW-1:0]          row_sel;
		logic [PosW-1:0]             col;
		logic [WinW-1:0]             win;
		logic                        emit;
		logic                        last;
	} hmin_item_t;
endpackage
`default_nettype wire

[sv/window_minimum_filter_2d.sv]
// top level of the two-dimensional sliding window minimum filter
// channel   direction  handshake          payload
// cfg       in         cfg_write_en       cfg_index, cfg_data
// pixel     in         in_valid/in_stall  pixel_value
// result    out        out_valid/out_stall window_min, frame_last
// front takes one pixel per cycle while the 4-entry queue has room
// back pops one item at a time; an item with a result keeps it busy while it reads the
// earlier rows one by one through the single read port of the 32k-entry line store
// reset clears position, queue and handshake state; line store is not cleared
// a stalled result holds in the output register while the front keeps going
`default_nettype none
module window_minimum_filter_2d (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_write_en,
	input  wire logic [1:0]                           cfg_index,
	input  wire logic [wmf_pkg::SideW-1:0]            cfg_data,
	input  wire logic                                 in_valid,
	output wire logic                                 in_stall,
	input  wire logic signed [wmf_pkg::DataWidth-1:0] pixel_value,
	output wire logic                                 out_valid,
	input  wire logic                                 out_stall,
	output wire logic signed [wmf_pkg::DataWidth-1:0] window_min,
	output wire logic                                 frame_last
);
	wmf_pkg::hmin_item_t f_item, b_item;
	logic push, full, pop, nonempty, accept;

	assign in_stall = full;
	assign accept = in_valid && !full;

	wmf_front u_front (
		.clk, .arst_n, .cfg_write_en, .cfg_index, .cfg_data,
		.accept, .pixel(pixel_value), .push, .item(f_item)
	);

	wmf_queue u_queue (
		.clk, .arst_n, .push, .push_item(f_item), .full,
		.pop, .nonempty, .pop_item(b_item)
	);

	wmf_back u_back (
		.clk, .arst_n, .nonempty, .item(b_item), .pop,
		.out_valid, .out_stall, .out_min(window_min), .out_last(frame_last)
	);
endmodule
`default_nettype wire

[sv/wmf_front.sv]
// front end: position tracking and horizontal sliding minimum queue
`default_nettype none
module wmf_front (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_write_en,
	input  wire logic [1:0]                          cfg_index,
	input  wire logic [wmf_pkg::SideW-1:0]           cfg_data,
	input  wire logic                                accept,
	input  wire logic signed [wmf_pkg::DataWidth-1:0] pixel,
	output wire logic                                push,
	output wire wmf_pkg::hmin_item_t                 item
);
	logic [wmf_pkg::SideW-1:0] side_q;
	logic [wmf_pkg::WinW-1:0]  win_q;
	logic [wmf_pkg::PosW-1:0]  row_q, col_q;
	logic [wmf_pkg::CntW-1:0]  cnt_q;
	logic signed [wmf_pkg::DataWidth-1:0] q_q [wmf_pkg::MaxWin];
	logic signed [wmf_pkg::DataWidth-1:0] hist_q [wmf_pkg::MaxWin];

	logic [wmf_pkg::SideW-1:0] side_e;
	logic [wmf_pkg::WinW-1:0]  win_e;
	logic [wmf_pkg::PosW-1:0]  row_c, col_c;
	logic                      active, pop;
	logic [wmf_pkg::CntW-1:0]  cnt0, cnt1, keep_n, cnt_n;
	logic signed [wmf_pkg::DataWidth-1:0] q1 [wmf_pkg::MaxWin];
	logic signed [wmf_pkg::DataWidth-1:0] qn [wmf_pkg::MaxWin];
	logic [wmf_pkg::MaxWin-1:0] keep;
	logic [wmf_pkg::RowSelW-1:0] leave_idx;
	logic [wmf_pkg::SideW-1:0] col_inc, row_inc;

	always_comb begin
		side_e = (side_q == '0) ? wmf_pkg::SideW'(1) :
			(side_q > wmf_pkg::SideW'(wmf_pkg::MaxSide)) ?
			wmf_pkg::SideW'(wmf_pkg::MaxSide) : side_q;
		win_e = (win_q == '0) ? wmf_pkg::WinW'(1) :
			(win_q > wmf_pkg::WinW'(wmf_pkg::MaxWin)) ? wmf_pkg::WinW'(wmf_pkg::MaxWin) : win_q;
		if ({1'b0, row_q} >= side_e || {1'b0, col_q} >= side_e) begin
			row_c = '0;
			col_c = '0;
		end else begin
			row_c = row_q;
			col_c = col_q;
		end
		cnt0 = (col_c == '0) ? '0 : cnt_q;
		active = {5'd0, win_e} <= side_e;
		leave_idx = col_c[wmf_pkg::RowSelW-1:0] - win_e[wmf_pkg::RowSelW-1:0];
		pop = ({4'd0, win_e} <= col_c) && (cnt0 != '0) && (hist_q[leave_idx] == q_q[0]);
		for (int i = 0; i < wmf_pkg::MaxWin; i++) begin
			if (pop && i < wmf_pkg::MaxWin - 1) q1[i] = q_q[(i + 1) % wmf_pkg::MaxWin];
			else q1[i] = q_q[i];
		end
		cnt1 = cnt0 - wmf_pkg::CntW'(pop);
		for (int i = 0; i < wmf_pkg::MaxWin; i++)
			keep[i] = (wmf_pkg::CntW'(i) < cnt1) && (q1[i] <= pixel);
		keep_n = wmf_pkg::CntW'($countones(keep));
		for (int i = 0; i < wmf_pkg::MaxWin; i++)
			qn[i] = (wmf_pkg::CntW'(i) == keep_n) ? pixel : q1[i];
		cnt_n = (keep_n < wmf_pkg::CntW'(wmf_pkg::MaxWin)) ? keep_n + 1'b1 : keep_n;
		col_inc = {1'b0, col_c} + 1'b1;
		row_inc = {1'b0, row_c} + 1'b1;
	end

	assign push = accept && active && (col_inc >= {5'd0, win_e});
	assign item.hmin = qn[0];
	assign item.row_sel = row_c[wmf_pkg::RowSelW-1:0];
	assign item.col = col_c;
	assign item.win = win_e;
	assign item.emit = row_inc >= {5'd0, win_e};
	assign item.last = (row_inc == side_e) && (col_inc == side_e);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= wmf_pkg::SideW'(1);
			win_q <= wmf_pkg::WinW'(1);
			row_q <= '0;
			col_q <= '0;
			cnt_q <= '0;
		end else if (cfg_write_en) begin
			if (cfg_index == wmf_pkg::RegImageSide) begin
				side_q <= cfg_data;
				row_q <= '0;
				col_q <= '0;
				cnt_q <= '0;
			end else if (cfg_index == wmf_pkg::RegWindowSize) begin
				win_q <= cfg_data[wmf_pkg::WinW-1:0];
				row_q <= '0;
				col_q <= '0;
				cnt_q <= '0;
			end
		end else if (accept) begin
			cnt_q <= active ? cnt_n : cnt0;
			if (col_inc >= side_e) begin
				col_q <= '0;
				row_q <= (row_inc >= side_e) ? '0 : row_inc[wmf_pkg::PosW-1:0];
			end else begin
				col_q <= col_inc[wmf_pkg::PosW-1:0];
				row_q <= row_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && active && !cfg_write_en) begin
			for (int i = 0; i < wmf_pkg::MaxWin; i++) q_q[i] <= qn[i];
			hist_q[col_c[wmf_pkg::RowSelW-1:0]] <= pixel;
		end
	end
endmodule
`default_nettype wire

[sv/wmf_queue.sv]
// short queue of horizontal minima between front and back
`default_nettype none
module wmf_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire wmf_pkg::hmin_item_t push_item,
	output wire logic                full,
	input  wire logic                pop,
	output wire logic                nonempty,
	output wire wmf_pkg::hmin_item_t pop_item
);
	wmf_pkg::hmin_item_t mem_q [wmf_pkg::QueueDepth];
	logic [wmf_pkg::QPtrW-1:0] wr_q, rd_q;
	logic [wmf_pkg::QCntW-1:0] cnt_q;

	assign full = cnt_q == wmf_pkg::QCntW'(wmf_pkg::QueueDepth);
	assign nonempty = cnt_q != '0;
	assign pop_item = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + wmf_pkg::QCntW'(push) - wmf_pkg::QCntW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end
endmodule
`default_nettype wire

[sv/wmf_back.sv]
// back end: line store of horizontal minima and vertical minimum
`default_nettype none
module wmf_back (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 nonempty,
	input  wire wmf_pkg::hmin_item_t                  item,
	output wire logic                                 pop,
	output wire logic                                 out_valid,
	input  wire logic                                 out_stall,
	output wire logic signed [wmf_pkg::DataWidth-1:0] out_min,
	output wire logic                                 out_last
);
	typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_CMP, ST_DONE} state_t;
	localparam int AddrW = wmf_pkg::RowSelW + wmf_pkg::PosW;

	state_t state_q;
	logic signed [wmf_pkg::DataWidth-1:0] line_q [2**AddrW];
	logic signed [wmf_pkg::DataWidth-1:0] rdata_q, min_q, omin_q;
	logic [wmf_pkg::RowSelW-1:0] row_q, k_q;
	logic [wmf_pkg::PosW-1:0] col_q;
	logic [wmf_pkg::WinW-1:0] win_q;
	logic last_q, ovalid_q, olast_q;
	logic [AddrW-1:0] rd_addr;
	logic signed [wmf_pkg::DataWidth-1:0] min_n;

	assign pop = (state_q == ST_IDLE) && nonempty;
	assign rd_addr = {row_q - k_q, col_q};
	assign min_n = (rdata_q < min_q) ? rdata_q : min_q;
	assign out_valid = ovalid_q;
	assign out_min = omin_q;
	assign out_last = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ovalid_q <= 1'b0;
			omin_q <= '0;
			olast_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && (!ovalid_q || !out_stall)) ovalid_q <= 1'b1;
			else if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (nonempty && item.emit) begin
						state_q <= (item.win == wmf_pkg::WinW'(1)) ? ST_DONE : ST_READ;
					end
				end
				ST_READ: state_q <= ST_CMP;
				ST_CMP: begin
					if ({1'b0, k_q} == win_q - 1'b1) state_q <= ST_DONE;
					else state_q <= ST_READ;
				end
				ST_DONE: begin
					if (!ovalid_q || !out_stall) begin
						omin_q <= min_q;
						olast_q <= last_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= line_q[rd_addr];
		case (state_q)
			ST_IDLE: begin
				if (nonempty) begin
					line_q[{item.row_sel, item.col}] <= item.hmin;
					min_q <= item.hmin;
					row_q <= item.row_sel;
					col_q <= item.col;
					win_q <= item.win;
					last_q <= item.last;
					k_q <= wmf_pkg::RowSelW'(1);
				end
			end
			ST_CMP: begin
				min_q <= min_n;
				k_q <= k_q + 1'b1;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

[sv/wmf_checker.sv]
// port checker for the window minimum filter, bound to the top level
`default_nettype none
module wmf_checker (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 out_valid,
	input wire logic                                 out_stall,
	input wire logic signed [wmf_pkg::DataWidth-1:0] window_min,
	input wire logic                                 frame_last
);
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(window_min) && $stable(frame_last))
		else $error("result changed");
	a_valid_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(out_valid))
		else $error("result valid unknown");
endmodule

bind window_minimum_filter_2d wmf_checker u_wmf_checker (
	.clk, .arst_n, .out_valid, .out_stall, .window_min, .frame_last
);
`default_nettype wire

[tb/tb_window_minimum_filter_2d.sv]
// self-checking testbench for the two-dimensional sliding window minimum filter
`timescale 1ns / 100ps
`default_nettype none
module tb_window_minimum_filter_2d;
	typedef struct {
		logic signed [wmf_pkg::DataWidth-1:0] min_val;
		logic                                 last;
	} win_result_t;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 cfg_write_en;
	logic [1:0]                           cfg_index;
	logic [wmf_pkg::SideW-1:0]            cfg_data;
	logic                                 in_valid;
	logic                                 in_stall;
	logic signed [wmf_pkg::DataWidth-1:0] pixel_value;
	logic                                 out_valid;
	logic                                 out_stall;
	logic signed [wmf_pkg::DataWidth-1:0] window_min;
	logic                                 frame_last;

	logic signed [wmf_pkg::DataWidth-1:0] pixel_fifo[$];
	win_result_t                          result_fifo[$];

	// predictor state
	logic [wmf_pkg::SideW-1:0]            side_reg;
	logic [wmf_pkg::WinW-1:0]             win_reg;
	logic signed [wmf_pkg::DataWidth-1:0] mono_q[wmf_pkg::MaxWin];
	int                                   mono_cnt;
	logic signed [wmf_pkg::DataWidth-1:0] row_hist[wmf_pkg::MaxWin];
	logic signed [wmf_pkg::DataWidth-1:0] line_mins[wmf_pkg::MaxWin][wmf_pkg::MaxSide];
	int                                   pos_row;
	int                                   pos_col;

	int  fail_count;
	int  pixel_count;
	int  result_count;
	int  last_count;
	int  phase_count;
	bit  quiet_in;
	bit  quiet_out;
	bit  hold_req;
	int  hold_len;
	int  in_gap;
	int  hold_left;

	window_minimum_filter_2d u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pixel_value  (pixel_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.window_min   (window_min),
		.frame_last   (frame_last)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic int pick_gap(bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [wmf_pkg::DataWidth-1:0] pick_pixel();
		case ($urandom_range(0, 9))
			6, 7:    return $urandom;
			8:       return 32'sh8000_0000;
			9:       return 32'sh7fff_ffff;
			default: return $signed($urandom_range(0, 6)) - 3;
		endcase
	endfunction

	task automatic add_pixel(input logic signed [wmf_pkg::DataWidth-1:0] v);
		pixel_fifo.insert(pixel_fifo.size(), v);
	endtask

	task automatic restart_position();
		pos_row  = 0;
		pos_col  = 0;
		mono_cnt = 0;
	endtask

	task automatic predict_window_min(input logic signed [wmf_pkg::DataWidth-1:0] x);
		int s;
		int w;
		int r;
		int c;
		int k;
		logic signed [wmf_pkg::DataWidth-1:0] m;
		win_result_t res;
		s = (side_reg == 0) ? 1 :
			(side_reg > wmf_pkg::MaxSide) ? wmf_pkg::MaxSide : int'(side_reg);
		w = (win_reg == 0) ? 1 :
			(win_reg > wmf_pkg::MaxWin) ? wmf_pkg::MaxWin : int'(win_reg);
		r = pos_row;
		c = pos_col;
		if (r >= s || c >= s) begin
			restart_position();
			r = 0;
			c = 0;
		end
		if (c == 0)
			mono_cnt = 0;
		if (w <= s) begin
			// expire the head when the value leaving the window equals it
			if (c >= w && mono_cnt > 0) begin
				if (row_hist[(c - w) % wmf_pkg::MaxWin] == mono_q[0]) begin
					for (k = 0; k < mono_cnt - 1; k++)
						mono_q[k] = mono_q[k + 1];
					mono_cnt--;
				end
			end
			while (mono_cnt > 0 && mono_q[mono_cnt - 1] > x)
				mono_cnt--;
			if (mono_cnt < wmf_pkg::MaxWin) begin
				mono_q[mono_cnt] = x;
				mono_cnt++;
			end
			row_hist[c % wmf_pkg::MaxWin] = x;
			if (c + 1 >= w) begin
				line_mins[r % wmf_pkg::MaxWin][c] = mono_q[0];
				if (r + 1 >= w) begin
					m = mono_q[0];
					for (k = 1; k < w; k++)
						if (line_mins[(r - k) % wmf_pkg::MaxWin][c] < m)
							m = line_mins[(r - k) % wmf_pkg::MaxWin][c];
					res.min_val = m;
					res.last    = (r + 1 == s) && (c + 1 == s);
					result_fifo.insert(result_fifo.size(), res);
				end
			end
		end
		c++;
		if (c >= s) begin
			c = 0;
			r++;
			if (r >= s)
				r = 0;
		end
		pos_row = r;
		pos_col = c;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			pixel_value <= '0;
			in_gap      = 0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_window_min(pixel_value);
				pixel_count++;
			end
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pixel_fifo.size() > 0) begin
					in_valid    <= 1'b1;
					pixel_value <= pixel_fifo[0];
					pixel_fifo.delete(0);
					in_gap      = pick_gap(quiet_in);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off counter
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_req && hold_left == 0)
			hold_left <= hold_len;
		else if (hold_left > 0)
			hold_left <= hold_left - 1;
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		win_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (result_fifo.size() == 0) begin
					$error("unexpected result transaction: window_min %0d frame_last %0b",
						window_min, frame_last);
					fail_count++;
				end else begin
					want = result_fifo[0];
					result_fifo.delete(0);
					result_count++;
					if (want.last)
						last_count++;
					if (window_min !== want.min_val) begin
						$error("window_min expected %0d actual %0d", want.min_val, window_min);
						fail_count++;
					end
					if (frame_last !== want.last) begin
						$error("frame_last expected %0b actual %0b", want.last, frame_last);
						fail_count++;
					end
				end
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
			end else if (quiet_out) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= (pick_gap(1'b0) > 0);
			end
		end
	end

	task automatic wait_idle();
		do
			@(posedge clk);
		while (pixel_fifo.size() != 0 || in_valid || result_fifo.size() != 0);
		repeat (600) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [wmf_pkg::SideW-1:0] data);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= data;
		if (idx == wmf_pkg::RegImageSide)
			side_reg = data;
		else if (idx == wmf_pkg::RegWindowSize)
			win_reg = data[wmf_pkg::WinW-1:0];
		restart_position();
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	task automatic setup(input logic [wmf_pkg::SideW-1:0] side,
		input logic [wmf_pkg::SideW-1:0] win);
		wait_idle();
		phase_count++;
		if ($urandom_range(0, 1)) begin
			write_reg(wmf_pkg::RegImageSide, side);
			write_reg(wmf_pkg::RegWindowSize, win);
		end else begin
			write_reg(wmf_pkg::RegWindowSize, win);
			write_reg(wmf_pkg::RegImageSide, side);
		end
		quiet_in  = ($urandom_range(0, 3) == 0);
		quiet_out = ($urandom_range(0, 3) == 0);
	endtask

	task automatic push_random(input int n);
		repeat (n) add_pixel(pick_pixel());
	endtask

	initial begin
		int rand_items;
		int side;
		int win;
		int n;
		int ties[12];
		fail_count   = 0;
		pixel_count  = 0;
		result_count = 0;
		last_count   = 0;
		phase_count  = 0;
		quiet_in     = 1'b0;
		quiet_out    = 1'b0;
		hold_req     = 1'b0;
		hold_len     = 0;
		side_reg     = 1;
		win_reg      = 1;
		restart_position();
		arst_n       = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index    = wmf_pkg::RegImageSide;
		cfg_data     = '0;
		ties         = '{5, 5, 3, 5, -1, -1, 2, -1, 7, 4, 4, 4};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, one pixel per frame
		add_pixel(0);
		add_pixel(32'sh7fff_ffff);
		add_pixel(32'sh8000_0000);
		add_pixel(-1);
		add_pixel(1);

		// ties so the queue head expires on equal values, then wrap into a new frame
		setup(3, 2);
		foreach (ties[i])
			add_pixel(ties[i]);

		// zero side and window act as one
		setup(0, 0);
		push_random(3);

		// window larger than side gives nothing
		setup(4, 5);
		push_random(6);

		// side above the maximum, upper bits of window data ignored
		setup(2047, 11'h7C1);
		push_random(20);

		// long receiver hold-off while the sender keeps going
		setup(4, 1);
		quiet_in = 1'b1;
		@(negedge clk);
		hold_len = 300;
		hold_req = 1'b1;
		@(negedge clk);
		hold_req = 1'b0;
		push_random(40);

		// wide window over a full frame
		setup(12, 12);
		push_random(144);

		// restart in the middle of a frame with unchanged settings
		setup(5, 2);
		push_random(13);
		wait_idle();
		write_reg(wmf_pkg::RegImageSide, 5);
		push_random(30);

		rand_items = 0;
		while (rand_items < 240) begin
			side = $urandom_range(1, 9);
			win  = $urandom_range(0, side + 1);
			n    = side * side * $urandom_range(1, 2) + $urandom_range(0, side);
			setup(wmf_pkg::SideW'(side), wmf_pkg::SideW'(win));
			push_random(n);
			rand_items += n;
		end

		wait_idle();
		if (result_fifo.size() != 0) begin
			$error("%0d expected results never arrived", result_fifo.size());
			fail_count++;
		end
		$display("covered %0d pixel transactions in %0d settings", pixel_count, phase_count);
		$display("checked %0d window results, %0d of them frame ends", result_count, last_count);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire
